// ===== rtl/core/srd_pkg.sv =====
package srd_pkg;

   // Block configuration
   localparam int HISTORY_DEPTH = 3;
   localparam int ANGLE_BITS    = 24;

   // Field widths fixed by the interface
   localparam int QUALITY_W  = 3;
   localparam int INTERVAL_W = 16;
   localparam int MIN_W      = 18;
   localparam int RATE_W     = 32;

   // Derived widths
   localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int IVAL_DEPTH = (HISTORY_DEPTH > 1) ? HISTORY_DEPTH - 1 : 1;
   localparam int TOTAL_W    = INTERVAL_W + $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W      = (TOTAL_W > MIN_W) ? TOTAL_W : MIN_W;
   localparam int SCALE_W    = 20;
   localparam int PROD_W     = ANGLE_BITS + SCALE_W;
   localparam int DIV_CNT_W  = $clog2(PROD_W);

   // Angle LSB per microsecond to angle LSB per second
   localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000000);

   // Quality codes
   localparam logic [QUALITY_W-1:0] QUALITY_OK      = QUALITY_W'(0);
   localparam logic [QUALITY_W-1:0] QUALITY_MISSING = QUALITY_W'(1);

   typedef struct packed {
      logic capture;
      logic eval;
      logic mult;
      logic div_step;
      logic load_out;
   } srd_cmd_type;

endpackage

// ===== rtl/core/srd_ctrl.sv =====
module srd_ctrl
   import srd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        eval_fault,
   output srd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MULT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

   state_type              state_ff;
   logic [DIV_CNT_W-1:0]   count_ff;
   logic                   rsp_valid_ff;
   logic                   out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.capture  = req_valid && (state_ff == ST_IDLE);
      cmd.eval     = (state_ff == ST_EVAL);
      cmd.mult     = (state_ff == ST_MULT);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.load_out = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               // a faulted request skips the arithmetic
               state_ff <= eval_fault ? ST_FINISH : ST_MULT;
            end
            ST_MULT: begin
               count_ff <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (count_ff == DIV_LAST) begin
                  state_ff <= ST_FINISH;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/srd_datapath.sv =====
module srd_datapath
   import srd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  srd_cmd_type                  cmd,
   output logic                         eval_fault,
   input  logic                         csr_write_enable,
   input  logic [MIN_W-1:0]             csr_min_interval_us,
   input  logic signed [ANGLE_BITS-1:0] req_angle_sample,
   input  logic [QUALITY_W-1:0]         req_angle_quality,
   input  logic [INTERVAL_W-1:0]        req_cycle_time_us,
   output logic signed [RATE_W-1:0]     rsp_rate,
   output logic [QUALITY_W-1:0]         rsp_rate_quality
);

   localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(64'h7FFF_FFFF);
   localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'h8000_0000);

   // configuration
   logic [MIN_W-1:0]             min_interval_ff;

   // captured request
   logic signed [ANGLE_BITS-1:0] angle_ff;
   logic [QUALITY_W-1:0]         quality_ff;
   logic [INTERVAL_W-1:0]        cycle_ff;

   // history
   logic signed [ANGLE_BITS-1:0] angle_hist_ff [HISTORY_DEPTH];
   logic signed [ANGLE_BITS-1:0] angle_hist_in [HISTORY_DEPTH];
   logic [INTERVAL_W-1:0]        ival_hist_ff  [IVAL_DEPTH];
   logic [INTERVAL_W-1:0]        ival_hist_in  [IVAL_DEPTH];
   logic [FILL_W-1:0]            fill_ff;
   logic [FILL_W-1:0]            fill_in;

   // evaluation
   logic [HIST_IDX_W-1:0]        oldest_idx;
   logic signed [ANGLE_BITS:0]   diff;
   logic [ANGLE_BITS-1:0]        mag;
   logic [TOTAL_W-1:0]           total;
   logic                         time_fault;
   logic                         fault;

   // arithmetic registers
   logic [ANGLE_BITS-1:0]        mag_ff;
   logic                         neg_ff;
   logic [TOTAL_W-1:0]           total_ff;
   logic                         fault_ff;
   logic [QUALITY_W-1:0]         res_quality_ff;
   logic [QUALITY_W-1:0]         res_quality_in;
   logic [PROD_W-1:0]            quo_ff;
   logic [TOTAL_W-1:0]           rem_ff;

   // divider step
   logic [TOTAL_W:0]             rem_shift;
   logic                         rem_ge;
   logic [TOTAL_W-1:0]           rem_in;
   logic [PROD_W-1:0]            quo_in;

   // output
   logic signed [RATE_W-1:0]     rate_sat;
   logic signed [RATE_W-1:0]     rsp_rate_ff;
   logic [QUALITY_W-1:0]         rsp_quality_ff;

   assign oldest_idx = HIST_IDX_W'(fill_ff - 1'b1);

   always_comb begin
      total = TOTAL_W'(cycle_ff);
      for (int i = 0; i < IVAL_DEPTH; i++) begin
         if (FILL_W'(i + 1) < fill_ff) begin
            total = total + TOTAL_W'(ival_hist_ff[i]);
         end
      end
      if (fill_ff == '0) begin
         diff = '0;
      end else begin
         diff = (ANGLE_BITS + 1)'(angle_ff) - (ANGLE_BITS + 1)'(angle_hist_ff[oldest_idx]);
      end
      mag = diff[ANGLE_BITS] ? ANGLE_BITS'(-diff) : diff[ANGLE_BITS-1:0];
   end

   assign time_fault = (CMP_W'(total) <= CMP_W'(min_interval_ff));
   assign fault      = (quality_ff != QUALITY_OK) || time_fault;
   assign eval_fault = fault;

   always_comb begin
      if (quality_ff != QUALITY_OK) begin
         res_quality_in = quality_ff;
      end else if (time_fault) begin
         res_quality_in = QUALITY_MISSING;
      end else begin
         res_quality_in = QUALITY_OK;
      end
   end

   // next history: clear on a fault, shift in the new sample otherwise
   always_comb begin
      if (fault) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            angle_hist_in[i] = '0;
         end
         for (int i = 0; i < IVAL_DEPTH; i++) begin
            ival_hist_in[i] = '0;
         end
         fill_in = '0;
      end else begin
         angle_hist_in[0] = angle_ff;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            angle_hist_in[i] = angle_hist_ff[i-1];
         end
         ival_hist_in[0] = cycle_ff;
         for (int i = 1; i < IVAL_DEPTH; i++) begin
            ival_hist_in[i] = ival_hist_ff[i-1];
         end
         fill_in = (fill_ff < FILL_W'(HISTORY_DEPTH)) ? fill_ff + 1'b1 : fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= '0;
         fill_ff         <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            angle_hist_ff[i] <= '0;
         end
         for (int i = 0; i < IVAL_DEPTH; i++) begin
            ival_hist_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            min_interval_ff <= csr_min_interval_us;
         end
         if (cmd.eval) begin
            fill_ff       <= fill_in;
            angle_hist_ff <= angle_hist_in;
            ival_hist_ff  <= ival_hist_in;
         end
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, total_ff});
   assign rem_in    = rem_ge ? TOTAL_W'(rem_shift - {1'b0, total_ff})
                             : rem_shift[TOTAL_W-1:0];
   assign quo_in    = {quo_ff[PROD_W-2:0], rem_ge};

   always_comb begin
      if (fault_ff) begin
         rate_sat = '0;
      end else if (neg_ff) begin
         rate_sat = (quo_ff > NEG_LIMIT) ? RATE_W'(NEG_LIMIT)
                                         : -quo_ff[RATE_W-1:0];
      end else begin
         rate_sat = (quo_ff > POS_LIMIT) ? RATE_W'(POS_LIMIT) : quo_ff[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         angle_ff   <= req_angle_sample;
         quality_ff <= req_angle_quality;
         cycle_ff   <= req_cycle_time_us;
      end
      if (cmd.eval) begin
         mag_ff         <= mag;
         neg_ff         <= diff[ANGLE_BITS];
         total_ff       <= total;
         fault_ff       <= fault;
         res_quality_ff <= res_quality_in;
      end
      if (cmd.mult) begin
         quo_ff <= PROD_W'(mag_ff) * PROD_W'(RATE_SCALE);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.load_out) begin
         rsp_rate_ff    <= rate_sat;
         rsp_quality_ff <= res_quality_ff;
      end
   end

   assign rsp_rate         = rsp_rate_ff;
   assign rsp_rate_quality = rsp_quality_ff;

endmodule

// ===== rtl/core/steering_rate_differentiator.sv =====
// Steering angle rate from a backward difference over up to three sample intervals.
// Request channel: req_valid / req_stall carry an angle sample, its quality
// code and the time since the previous sample. Response channel: rsp_valid /
// rsp_stall carry the rate (angle LSB per second, saturated) and its quality.
// csr_write_enable writes csr_min_interval_us; write it only while idle.
// A valid request passes through an evaluate state, a multiply state,
// 44 restoring divider steps (one quotient bit each) and an output load.
// A request with bad quality or a time fault skips the multiply and divide.
// The bit-serial divider bounds the request rate: a new request is taken
// only after the previous one has been loaded into the output register.
// req_stall is high while a request is in work. The response sits in an
// output register, so the next request is taken while the response waits;
// if the receiver stalls, the next finished response holds until the
// register frees up. Reset clears the history, the warm-up count, the
// threshold and rsp_valid.
module steering_rate_differentiator
   import srd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ANGLE_BITS-1:0] req_angle_sample,
   input  logic [QUALITY_W-1:0]         req_angle_quality,
   input  logic [INTERVAL_W-1:0]        req_cycle_time_us,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [RATE_W-1:0]     rsp_rate,
   output logic [QUALITY_W-1:0]         rsp_rate_quality,
   input  logic                         csr_write_enable,
   input  logic [MIN_W-1:0]             csr_min_interval_us
);

   srd_cmd_type cmd;
   logic        eval_fault;

   srd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .eval_fault (eval_fault),
      .cmd        (cmd)
   );

   srd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .eval_fault          (eval_fault),
      .csr_write_enable    (csr_write_enable),
      .csr_min_interval_us (csr_min_interval_us),
      .req_angle_sample    (req_angle_sample),
      .req_angle_quality   (req_angle_quality),
      .req_cycle_time_us   (req_cycle_time_us),
      .rsp_rate            (rsp_rate),
      .rsp_rate_quality    (rsp_rate_quality)
   );

endmodule

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srd_pkg::*;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      logic [QUALITY_W-1:0]     quality;
   } rate_result_type;

   localparam logic signed [ANGLE_BITS-1:0] ANGLE_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
   localparam logic signed [ANGLE_BITS-1:0] ANGLE_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic signed [RATE_W-1:0]     RATE_MAX  = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0]     RATE_MIN  = {1'b1, {(RATE_W-1){1'b0}}};
   localparam logic [MIN_W-1:0]             MIN_INTERVAL_MAX = '1;
   localparam longint unsigned              US_PER_SEC = 1000000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STREAM_ITEMS    = 540;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [ANGLE_BITS-1:0] req_angle_sample = '0;
   logic [QUALITY_W-1:0]         req_angle_quality = QUALITY_OK;
   logic [INTERVAL_W-1:0]        req_cycle_time_us = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [RATE_W-1:0]     rsp_rate;
   logic [QUALITY_W-1:0]         rsp_rate_quality;
   logic                         csr_write_enable = 1'b0;
   logic [MIN_W-1:0]             csr_min_interval_us = '0;

   steering_rate_differentiator u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_angle_sample    (req_angle_sample),
      .req_angle_quality   (req_angle_quality),
      .req_cycle_time_us   (req_cycle_time_us),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rate            (rsp_rate),
      .rsp_rate_quality    (rsp_rate_quality),
      .csr_write_enable    (csr_write_enable),
      .csr_min_interval_us (csr_min_interval_us)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Rate predictor state
   logic signed [ANGLE_BITS-1:0] angle_hist [HISTORY_DEPTH];
   logic [INTERVAL_W-1:0]        ival_hist [IVAL_DEPTH];
   int unsigned                  fill_level = 0;
   logic [MIN_W-1:0]             min_interval = '0;

   rate_result_type              expected_rates [$];
   rate_result_type              oldest_rate;
   int                           failures = 0;
   int unsigned                  send_idle_pct = 0;
   int unsigned                  recv_idle_pct = 0;
   int unsigned                  hold_tag = 0;
   int unsigned                  hold_seen = 0;
   int unsigned                  hold_left = 0;
   logic signed [ANGLE_BITS-1:0] walk_angle = '0;

   initial begin
      foreach (angle_hist[i]) angle_hist[i] = '0;
      foreach (ival_hist[i]) ival_hist[i] = '0;
   end

   function automatic void clear_history();
      int i;
      for (i = 0; i < HISTORY_DEPTH; i++) angle_hist[i] = '0;
      for (i = 0; i < IVAL_DEPTH; i++) ival_hist[i] = '0;
      fill_level = 0;
   endfunction

   function automatic rate_result_type predict_rate(input logic signed [ANGLE_BITS-1:0] angle,
                                                    input logic [QUALITY_W-1:0] quality,
                                                    input logic [INTERVAL_W-1:0] cycle_us);
      rate_result_type   r;
      int unsigned       span;
      int unsigned       i;
      longint            diff;
      longint unsigned   total;
      longint unsigned   mag;
      longint unsigned   quo;
      r.rate = '0;
      r.quality = quality;
      if (quality != QUALITY_OK) begin
         clear_history();
         return r;
      end
      span = (fill_level > HISTORY_DEPTH) ? HISTORY_DEPTH : fill_level;
      total = cycle_us;
      diff = 0;
      if (span != 0) begin
         diff = longint'(angle) - longint'(angle_hist[span-1]);
         for (i = 0; i + 1 < span; i++) total += ival_hist[i];
      end
      // Summed time at or below the threshold is a time fault
      if (total <= 64'(min_interval)) begin
         r.quality = QUALITY_MISSING;
         clear_history();
         return r;
      end
      mag = (diff < 0) ? longint'(-diff) : longint'(diff);
      quo = (mag * US_PER_SEC) / total;
      if (diff < 0)
         r.rate = (quo > 64'd2147483648) ? RATE_MIN : RATE_W'(-longint'(quo));
      else
         r.rate = (quo > 64'd2147483647) ? RATE_MAX : RATE_W'(quo);
      for (i = HISTORY_DEPTH - 1; i > 0; i--) angle_hist[i] = angle_hist[i-1];
      angle_hist[0] = angle;
      for (i = IVAL_DEPTH - 1; i > 0; i--) ival_hist[i] = ival_hist[i-1];
      ival_hist[0] = cycle_us;
      if (fill_level < HISTORY_DEPTH) fill_level++;
      return r;
   endfunction

   // Receiver: random stall, or a long hold-off when a new one is requested
   always @(posedge clock) begin
      if (hold_tag != hold_seen) begin
         hold_seen <= hold_tag;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rates.size() == 0) begin
            $error("response with no request pending: rate %0d, rate_quality %0d",
                   rsp_rate, rsp_rate_quality);
            failures++;
         end else begin
            oldest_rate = expected_rates.pop_front();
            if (rsp_rate !== oldest_rate.rate) begin
               $error("rate: expected %0d, actual %0d", oldest_rate.rate, rsp_rate);
               failures++;
            end
            if (rsp_rate_quality !== oldest_rate.quality) begin
               $error("rate_quality: expected %0d, actual %0d",
                      oldest_rate.quality, rsp_rate_quality);
               failures++;
            end
         end
      end
   end

   task automatic send_request(input logic signed [ANGLE_BITS-1:0] angle,
                               input logic [QUALITY_W-1:0] quality,
                               input logic [INTERVAL_W-1:0] cycle_us);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_angle_sample <= angle;
      req_angle_quality <= quality;
      req_cycle_time_us <= cycle_us;
      do @(posedge clock); while (req_stall);
      expected_rates.push_back(predict_rate(angle, quality, cycle_us));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_interval(input logic [MIN_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_min_interval_us <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      min_interval = value;
   endtask

   task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Threshold is 0 from reset: a lone zero time faults, then fill the history
   task automatic test_warmup_and_zero_time();
      send_request(100, QUALITY_OK, 0);
      send_request(100, QUALITY_OK, 5000);
      send_request(164, QUALITY_OK, 5000);
      send_request(36, QUALITY_OK, 1000);
      send_request(200, QUALITY_OK, 0);
   endtask

   task automatic test_bad_quality();
      int code;
      send_request(25, QUALITY_OK, 2000);
      for (code = 1; code < (1 << QUALITY_W); code++)
         send_request(ANGLE_BITS'(code * 100), QUALITY_W'(code), 2000);
      send_request(-25, QUALITY_OK, 2000);
   endtask

   task automatic test_saturation();
      send_request(0, QUALITY_MISSING, 1);
      send_request(ANGLE_MAX, QUALITY_OK, 1);
      send_request(ANGLE_MIN, QUALITY_OK, 1);
      send_request(ANGLE_MAX, QUALITY_OK, '1);
      send_request(ANGLE_MAX, QUALITY_OK, 1);
   endtask

   task automatic test_threshold();
      write_min_interval(MIN_INTERVAL_MAX);
      send_request(0, QUALITY_OK, '1);
      write_min_interval(1000);
      send_request(10, QUALITY_OK, 1000);
      send_request(10, QUALITY_OK, 1001);
      send_request(20, QUALITY_OK, 0);
      send_request(20, QUALITY_OK, 1001);
      send_request(30, QUALITY_OK, 1001);
      // Only the summed time clears the threshold here
      send_request(40, QUALITY_OK, 10);
   endtask

   task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [MIN_W-1:0] threshold, input int count);
      int                    n;
      int                    near;
      int unsigned           pick;
      logic [QUALITY_W-1:0]  quality;
      logic [INTERVAL_W-1:0] cycle_us;
      write_min_interval(threshold);
      set_idle(send_pct, recv_pct);
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 88)
            walk_angle += ANGLE_BITS'(int'($urandom_range(4000)) - 2000);
         else if (pick < 96)
            walk_angle = ANGLE_BITS'($urandom);
         else
            walk_angle = $urandom_range(1) ? ANGLE_MAX : ANGLE_MIN;
         quality = ($urandom_range(99) < 90) ? QUALITY_OK : QUALITY_W'($urandom_range(7, 1));
         pick = $urandom_range(99);
         if (pick < 55) begin
            cycle_us = INTERVAL_W'($urandom_range(20000, 1000));
         end else if (pick < 70) begin
            cycle_us = INTERVAL_W'($urandom_range(50));
         end else if (pick < 85) begin
            cycle_us = INTERVAL_W'($urandom);
         end else begin
            // Land near the threshold, alone or summed over the history
            near = int'(min_interval) / int'($urandom_range(3, 1))
                   + int'($urandom_range(4)) - 2;
            cycle_us = (near < 0) ? '0 : INTERVAL_W'(near);
         end
         send_request(walk_angle, quality, cycle_us);
      end
   endtask

   task automatic test_backpressure();
      int n;
      write_min_interval(0);
      set_idle(0, 0);
      hold_tag++;
      for (n = 0; n < 8; n++) begin
         walk_angle += ANGLE_BITS'(int'($urandom_range(600)) - 300);
         send_request(walk_angle, QUALITY_OK, INTERVAL_W'($urandom_range(9000, 3000)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idle(30, 62);
      test_warmup_and_zero_time();
      test_bad_quality();
      test_saturation();
      test_threshold();
      test_random_stream(30, 62, 0, STREAM_ITEMS);
      test_random_stream(62, 30, MIN_W'($urandom_range(3000, 100)), STREAM_ITEMS);
      test_random_stream(0, 0, MIN_W'($urandom_range(40000, 1)), STREAM_ITEMS);
      test_backpressure();
      wait_idle();
      if (failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/srd_pkg.sv
rtl/core/srd_ctrl.sv
rtl/core/srd_datapath.sv
rtl/core/steering_rate_differentiator.sv
verif/tb.sv
